// ===== rtl/assert_macros.svh =====
// Assertion macros used by the core module of the JSON string escaper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/jse_pkg.sv =====
// Package with types, byte codes and helpers of the JSON string escaper.
`default_nettype none

package jse_pkg;

   localparam int unsigned MaxOut = 16;
   localparam int unsigned BufW   = MaxOut * 8;

   localparam logic [7:0] QUOTE   = 8'h22;
   localparam logic [7:0] BSLASH  = 8'h5C;
   localparam logic [7:0] CHAR_N  = 8'h6E;
   localparam logic [7:0] CHAR_R  = 8'h72;
   localparam logic [7:0] CHAR_T  = 8'h74;
   localparam logic [7:0] CHAR_U  = 8'h75;
   localparam logic [7:0] CHAR_0  = 8'h30;
   localparam logic [7:0] CODE_LF = 8'h0A;
   localparam logic [7:0] CODE_CR = 8'h0D;
   localparam logic [7:0] CODE_HT = 8'h09;

   localparam logic       CMD_BYTE = 1'b0;
   localparam logic       CMD_END  = 1'b1;

   // U+FFFD as UTF-8, first byte in the low bits.
   localparam logic [23:0] REP_VEC = 24'hBDBFEF;

   typedef logic [4:0] count_type;

   typedef struct packed {
      logic       open;
      logic [1:0] held_count;
      logic [2:0] exp_len;
   } ctl_type;

   typedef struct packed {
      logic [BufW-1:0] bytes;
      count_type       count;
      logic            closing;
   } run_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      logic [7:0] r;
      if (n < 4'd10) begin
         r = 8'h30 + {4'b0, n};
      end else begin
         r = 8'h57 + {4'b0, n};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/json_string_escaper_utf8_check_core.sv =====
// Top level of the JSON string escaper with UTF-8 validation.
//
//  Channel  Ports                                   Carries
//  req      req_valid/req_ready, req_cmd,           one raw byte or the end command
//           req_data_byte
//  rsp      rsp_valid/rsp_ready, rsp_out_byte,      one byte of quoted JSON text
//           rsp_closes_string, rsp_last_of_run
//
// A request is expanded in the cycle it is accepted and its 0 to 15 output bytes are
// loaded into a shift buffer, which sends one byte per cycle while rsp_ready is high.
// The next request is taken in the same cycle as the last byte of the previous one,
// so plain ASCII runs at one byte per cycle while rsp_ready is high. A request that
// yields no byte (a held UTF-8 byte) only updates the UTF-8 state.
// Reset is synchronous and clears the string, UTF-8 and buffer control state.
// A stalled output holds the current byte and blocks new requests.
`default_nettype none

module json_string_escaper_utf8_check_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_cmd,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_closes_string,
   output logic            rsp_last_of_run
);
   import jse_pkg::*;

   `include "assert_macros.svh"

   ctl_type         ctl_ff, ctl_in;
   logic [7:0]      held_ff [3];
   logic [7:0]      held_in [3];
   run_type         run;
   logic [BufW-1:0] buf_ff;
   count_type       rem_ff;
   logic            closing_ff;
   logic            req_take;
   logic            rsp_take;

   jse_expand u_expand (
      .ctl       (ctl_ff),
      .held      (held_ff),
      .cmd       (req_cmd),
      .data_byte (req_data_byte),
      .run       (run),
      .ctl_next  (ctl_in),
      .held_next (held_in)
   );

   assign rsp_valid         = (rem_ff != 5'd0);
   assign rsp_out_byte      = buf_ff[7:0];
   assign rsp_last_of_run   = (rem_ff == 5'd1);
   assign rsp_closes_string = closing_ff && (rem_ff == 5'd1);
   assign rsp_take          = rsp_valid && rsp_ready;
   assign req_ready         = (rem_ff == 5'd0) || ((rem_ff == 5'd1) && rsp_ready);
   assign req_take          = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
         rem_ff <= '0;
      end else begin
         if (req_take) begin
            ctl_ff <= ctl_in;
            rem_ff <= run.count;
         end else if (rsp_take) begin
            rem_ff <= rem_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         held_ff    <= held_in;
         buf_ff     <= run.bytes;
         closing_ff <= run.closing;
      end else if (rsp_take) begin
         buf_ff <= buf_ff >> 8;
      end
   end

   `ASSERT_NOW(a_take_only_on_drain, clock, reset, req_take && (rem_ff != 5'd0),
      (rem_ff == 5'd1) && rsp_ready, "request accepted while output bytes remain")
   `ASSERT_NOW(a_close_is_quote, clock, reset, rsp_valid && rsp_closes_string,
      (rsp_out_byte == QUOTE) && rsp_last_of_run, "closing byte is not a final quote")
   `ASSERT_NOW(a_held_consistent, clock, reset, ctl_ff.held_count != 2'd0,
      (ctl_ff.exp_len >= 3'd2) && ({1'b0, ctl_ff.held_count} < ctl_ff.exp_len),
      "held count does not fit the sequence length")
   `ASSERT_NEXT(a_end_closes, clock, reset, req_take && (req_cmd == CMD_END),
      !ctl_ff.open && (ctl_ff.held_count == 2'd0) && rsp_valid,
      "end request did not close the string")

endmodule

`default_nettype wire

// ===== rtl/jse_expand.sv =====
// Expansion of one request into the escaped output bytes and the next state.
`default_nettype none

module jse_expand (
   input  wire jse_pkg::ctl_type ctl,
   input  wire logic [7:0]       held [3],
   input  wire logic             cmd,
   input  wire logic [7:0]       data_byte,
   output jse_pkg::run_type      run,
   output jse_pkg::ctl_type      ctl_next,
   output logic [7:0]            held_next [3]
);
   import jse_pkg::*;

   logic [47:0] f_vec;
   logic [2:0]  f_len;
   logic        f_lead;
   logic [2:0]  f_lead_len;

   logic [20:0] cp;
   logic        cont;
   logic        complete;
   logic        cp_ok;

   logic        lq;
   logic [1:0]  r_cnt;
   logic [3:0]  lr;
   logic [71:0] rv;
   logic [95:0] mv;
   logic [3:0]  lm;
   logic        lc;
   logic [95:0] rep12;
   logic [95:0] pass_vec;
   logic        use_fresh;

   count_type   off_r;
   count_type   off_m;
   count_type   off_c;

   // Escape, pass-through, replacement or lead detection for a byte that starts fresh.
   always_comb begin
      f_vec      = '0;
      f_len      = 3'd0;
      f_lead     = 1'b0;
      f_lead_len = 3'd0;
      unique case (data_byte)
         QUOTE: begin
            f_vec = {32'b0, QUOTE, BSLASH};
            f_len = 3'd2;
         end
         BSLASH: begin
            f_vec = {32'b0, BSLASH, BSLASH};
            f_len = 3'd2;
         end
         CODE_LF: begin
            f_vec = {32'b0, CHAR_N, BSLASH};
            f_len = 3'd2;
         end
         CODE_CR: begin
            f_vec = {32'b0, CHAR_R, BSLASH};
            f_len = 3'd2;
         end
         CODE_HT: begin
            f_vec = {32'b0, CHAR_T, BSLASH};
            f_len = 3'd2;
         end
         default: begin
            if (data_byte < 8'h20) begin
               f_vec = {hex_digit(data_byte[3:0]), hex_digit(data_byte[7:4]),
                        CHAR_0, CHAR_0, CHAR_U, BSLASH};
               f_len = 3'd6;
            end else if (!data_byte[7]) begin
               f_vec = {40'b0, data_byte};
               f_len = 3'd1;
            end else if (data_byte[7:5] == 3'b110) begin
               f_lead     = 1'b1;
               f_lead_len = 3'd2;
            end else if (data_byte[7:4] == 4'b1110) begin
               f_lead     = 1'b1;
               f_lead_len = 3'd3;
            end else if (data_byte[7:3] == 5'b11110) begin
               f_lead     = 1'b1;
               f_lead_len = 3'd4;
            end else begin
               f_vec = {24'b0, REP_VEC};
               f_len = 3'd3;
            end
         end
      endcase
   end

   // Code point check and output choice for the request.
   always_comb begin
      cont     = (data_byte[7:6] == 2'b10);
      complete = (({1'b0, ctl.held_count} + 3'd1) == ctl.exp_len);

      unique case (ctl.exp_len)
         3'd2:    cp = {10'b0, held[0][4:0], data_byte[5:0]};
         3'd3:    cp = {5'b0, held[0][3:0], held[1][5:0], data_byte[5:0]};
         default: cp = {held[0][2:0], held[1][5:0], held[2][5:0], data_byte[5:0]};
      endcase

      cp_ok = 1'b1;
      if ((ctl.exp_len == 3'd2 && cp < 21'h80) || (ctl.exp_len == 3'd3 && cp < 21'h800) ||
          (ctl.exp_len == 3'd4 && cp < 21'h10000)) begin
         cp_ok = 1'b0;
      end
      if (cp >= 21'hD800 && cp <= 21'hDFFF) begin
         cp_ok = 1'b0;
      end
      if (cp > 21'h10FFFF) begin
         cp_ok = 1'b0;
      end

      unique case (ctl.exp_len)
         3'd2: begin
            pass_vec = {80'b0, data_byte, held[0]};
            rep12    = {48'b0, REP_VEC, REP_VEC};
         end
         3'd3: begin
            pass_vec = {72'b0, data_byte, held[1], held[0]};
            rep12    = {24'b0, REP_VEC, REP_VEC, REP_VEC};
         end
         default: begin
            pass_vec = {64'b0, data_byte, held[2], held[1], held[0]};
            rep12    = {REP_VEC, REP_VEC, REP_VEC, REP_VEC};
         end
      endcase

      lq        = !ctl.open;
      r_cnt     = 2'd0;
      lc        = 1'b0;
      mv        = '0;
      lm        = 4'd0;
      use_fresh = 1'b0;
      ctl_next  = ctl;
      ctl_next.open = 1'b1;
      held_next = held;

      if (cmd == CMD_END) begin
         r_cnt    = ctl.held_count;
         lc       = 1'b1;
         ctl_next = '0;
      end else if (ctl.held_count == 2'd0) begin
         use_fresh = 1'b1;
      end else if (!cont) begin
         // The lead and every held continuation byte each become U+FFFD.
         r_cnt     = ctl.held_count;
         use_fresh = 1'b1;
         ctl_next.held_count = 2'd0;
         ctl_next.exp_len    = 3'd0;
      end else if (!complete) begin
         held_next[ctl.held_count] = data_byte;
         ctl_next.held_count       = ctl.held_count + 2'd1;
      end else begin
         if (cp_ok) begin
            mv = pass_vec;
            lm = {1'b0, ctl.exp_len};
         end else begin
            mv = rep12;
            lm = {1'b0, ctl.exp_len} + {ctl.exp_len, 1'b0};
         end
         ctl_next.held_count = 2'd0;
         ctl_next.exp_len    = 3'd0;
      end

      if (use_fresh) begin
         mv = {48'b0, f_vec};
         lm = {1'b0, f_len};
         if (f_lead) begin
            held_next[0]        = data_byte;
            ctl_next.held_count = 2'd1;
            ctl_next.exp_len    = f_lead_len;
         end
      end

      case (r_cnt)
         2'd0:    rv = '0;
         2'd1:    rv = {48'b0, REP_VEC};
         2'd2:    rv = {24'b0, REP_VEC, REP_VEC};
         default: rv = {REP_VEC, REP_VEC, REP_VEC};
      endcase
      lr = {2'b0, r_cnt} + {1'b0, r_cnt, 1'b0};

      off_r = {4'b0, lq};
      off_m = off_r + {1'b0, lr};
      off_c = off_m + {1'b0, lm};

      run.bytes = {{(BufW - 8){1'b0}}, (lq ? QUOTE : 8'h00)}
                | ({{(BufW - 72){1'b0}}, rv} << {off_r, 3'b0})
                | ({{(BufW - 96){1'b0}}, mv} << {off_m, 3'b0})
                | ({{(BufW - 8){1'b0}}, (lc ? QUOTE : 8'h00)} << {off_c, 3'b0});
      run.count   = off_c + {4'b0, lc};
      run.closing = lc;
   end

endmodule

`default_nettype wire

// ===== test/json_escape_checker.sv =====
// Checker that predicts the escaped JSON text of each request and compares it with the output.
`timescale 1ns / 100ps

module json_escape_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_cmd,
   input  logic [7:0] req_data_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_closes_string,
   input  logic       rsp_last_of_run,
   output int         fail_count,
   output int         pending_count,
   output int         checked_count
);
   import jse_pkg::*;

   typedef struct packed {
      logic [7:0] text;
      logic       closing;
      logic       last;
   } text_byte_type;

   text_byte_type expected_text_q[$];

   // Escaper state as the block should hold it.
   logic       quote_open;
   logic [7:0] held[3];
   logic [1:0] held_n;
   logic [2:0] seq_len;
   int         run_len;

   function automatic void emit(input logic [7:0] b, input logic closing);
      text_byte_type item;
      if (run_len < MaxOut) begin
         item.text    = b;
         item.closing = closing;
         item.last    = 1'b0;
         expected_text_q = {expected_text_q, item};
         run_len++;
      end
   endfunction

   function automatic void emit_replacement();
      emit(REP_VEC[7:0], 1'b0);
      emit(REP_VEC[15:8], 1'b0);
      emit(REP_VEC[23:16], 1'b0);
   endfunction

   function automatic logic [7:0] nibble_char(input logic [3:0] n);
      return (n < 4'd10) ? 8'h30 + {4'h0, n} : 8'h61 + {4'h0, n} - 8'd10;
   endfunction

   function automatic void escape_byte(input logic [7:0] c);
      case (c)
         QUOTE:   begin emit(BSLASH, 1'b0); emit(QUOTE, 1'b0); end
         BSLASH:  begin emit(BSLASH, 1'b0); emit(BSLASH, 1'b0); end
         CODE_LF: begin emit(BSLASH, 1'b0); emit(CHAR_N, 1'b0); end
         CODE_CR: begin emit(BSLASH, 1'b0); emit(CHAR_R, 1'b0); end
         CODE_HT: begin emit(BSLASH, 1'b0); emit(CHAR_T, 1'b0); end
         default: begin
            if (c < 8'h20) begin
               emit(BSLASH, 1'b0);
               emit(CHAR_U, 1'b0);
               emit(CHAR_0, 1'b0);
               emit(CHAR_0, 1'b0);
               emit(nibble_char(c[7:4]), 1'b0);
               emit(nibble_char(c[3:0]), 1'b0);
            end else if (c < 8'h80) begin
               emit(c, 1'b0);
            end else begin
               if (c[7:5] == 3'b110) seq_len = 3'd2;
               else if (c[7:4] == 4'b1110) seq_len = 3'd3;
               else if (c[7:3] == 5'b11110) seq_len = 3'd4;
               else seq_len = 3'd0;
               if (seq_len == 3'd0) begin
                  emit_replacement();
               end else begin
                  held[0] = c;
                  held_n  = 2'd1;
               end
            end
         end
      endcase
   endfunction

   function automatic void extend_sequence(input logic [7:0] c);
      int unsigned cp;
      int          k;
      logic        good;
      if (c[7:6] != 2'b10) begin
         // The held bytes are rejected one by one and the breaking byte starts over.
         for (k = 0; k < int'(held_n); k++) emit_replacement();
         held_n  = 2'd0;
         seq_len = 3'd0;
         escape_byte(c);
      end else if (int'(held_n) + 1 < int'(seq_len)) begin
         held[held_n] = c;
         held_n++;
      end else begin
         case (seq_len)
            3'd2:    cp = 32'(held[0][4:0]);
            3'd3:    cp = 32'(held[0][3:0]);
            default: cp = 32'(held[0][2:0]);
         endcase
         for (k = 1; k < int'(seq_len) - 1; k++) cp = (cp << 6) | 32'(held[k][5:0]);
         cp = (cp << 6) | 32'(c[5:0]);
         good = 1'b1;
         if ((seq_len == 3'd2 && cp < 'h80) || (seq_len == 3'd3 && cp < 'h800) ||
             (seq_len == 3'd4 && cp < 'h10000)) good = 1'b0;
         if (cp >= 'hD800 && cp <= 'hDFFF) good = 1'b0;
         if (cp > 'h10FFFF) good = 1'b0;
         if (good) begin
            for (k = 0; k < int'(seq_len) - 1; k++) emit(held[k], 1'b0);
            emit(c, 1'b0);
         end else begin
            for (k = 0; k < int'(seq_len); k++) emit_replacement();
         end
         held_n  = 2'd0;
         seq_len = 3'd0;
      end
   endfunction

   function automatic void expand_request(input logic cmd, input logic [7:0] c);
      int k;
      run_len = 0;
      if (!quote_open) begin
         emit(QUOTE, 1'b0);
         quote_open = 1'b1;
      end
      if (cmd == CMD_BYTE) begin
         if (held_n != 2'd0) extend_sequence(c);
         else escape_byte(c);
      end else begin
         for (k = 0; k < int'(held_n); k++) emit_replacement();
         held_n  = 2'd0;
         seq_len = 3'd0;
         emit(QUOTE, 1'b1);
         quote_open = 1'b0;
      end
      if (run_len > 0) expected_text_q[expected_text_q.size() - 1].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      text_byte_type want;
      int            bad;
      bad = 0;
      if (reset) begin
         quote_open = 1'b0;
         held_n     = 2'd0;
         seq_len    = 3'd0;
         expected_text_q.delete();
      end else begin
         // Compare before predicting: a request taken at this edge cannot have output yet.
         if (rsp_valid && rsp_ready) begin
            if (expected_text_q.size() == 0) begin
               $error("output byte %h arrived with nothing expected", rsp_out_byte);
               bad++;
            end else begin
               want = expected_text_q.pop_front();
               if (rsp_out_byte !== want.text) begin
                  $error("out_byte: expected %h, actual %h", want.text, rsp_out_byte);
                  bad++;
               end
               if (rsp_closes_string !== want.closing) begin
                  $error("closes_string: expected %b, actual %b",
                         want.closing, rsp_closes_string);
                  bad++;
               end
               if (rsp_last_of_run !== want.last) begin
                  $error("last_of_run: expected %b, actual %b", want.last, rsp_last_of_run);
                  bad++;
               end
            end
            checked_count <= checked_count + 1;
         end
         if (req_valid && req_ready) expand_request(req_cmd, req_data_byte);
      end
      fail_count    <= fail_count + bad;
      pending_count <= expected_text_q.size();
   end

endmodule

// ===== test/json_string_escaper_utf8_check_core_tb.sv =====
// Testbench top for the JSON string escaper: stimulus, output stalls, watchdog and verdict.
`timescale 1ns / 100ps

module json_string_escaper_utf8_check_core_tb;
   import jse_pkg::*;

   localparam int IdleLimit   = 3000;
   localparam int RandomItems = 340;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_cmd;
   logic [7:0] req_data_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_closes_string;
   logic       rsp_last_of_run;

   int fail_count;
   int pending_count;
   int checked_count;
   int sent_count;
   int string_count;
   int burst_left;
   int idle_cycles;

   logic [7:0] string_bytes[$];

   json_string_escaper_utf8_check_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_closes_string (rsp_closes_string),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   json_escape_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_closes_string (rsp_closes_string),
      .rsp_last_of_run   (rsp_last_of_run),
      .fail_count        (fail_count),
      .pending_count     (pending_count),
      .checked_count     (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void append_byte(input logic [7:0] b);
      string_bytes = {string_bytes, b};
   endfunction

   function automatic void encode_cp(input logic [20:0] cp, input int len);
      case (len)
         2: begin
            append_byte({3'b110, cp[10:6]});
            append_byte({2'b10, cp[5:0]});
         end
         3: begin
            append_byte({4'b1110, cp[15:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
         default: begin
            append_byte({5'b11110, cp[20:18]});
            append_byte({2'b10, cp[17:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   function automatic void add_random_char();
      int          kind;
      int          len;
      int unsigned floor_cp;
      logic [7:0]  escapes[5];
      escapes = '{QUOTE, BSLASH, CODE_LF, CODE_CR, CODE_HT};
      kind = $urandom_range(0, 99);
      if (kind < 28) begin
         append_byte(8'($urandom_range('h20, 'h7E)));
      end else if (kind < 36) begin
         append_byte(escapes[$urandom_range(0, 4)]);
      end else if (kind < 43) begin
         append_byte(8'($urandom_range(0, 'h1F)));
      end else if (kind < 53) begin
         encode_cp(21'($urandom_range('h80, 'h7FF)), 2);
      end else if (kind < 61) begin
         encode_cp(21'($urandom_range('h800, 'hFFFF)), 3);
      end else if (kind < 68) begin
         encode_cp(21'($urandom_range('h10000, 'h10FFFF)), 4);
      end else if (kind < 72) begin
         // Overlong: a value small enough for a shorter form.
         len = $urandom_range(2, 4);
         floor_cp = (len == 2) ? 'h80 : (len == 3) ? 'h800 : 'h10000;
         encode_cp(21'($urandom_range(0, floor_cp - 1)), len);
      end else if (kind < 75) begin
         encode_cp(21'($urandom_range('hD800, 'hDFFF)), 3);
      end else if (kind < 78) begin
         encode_cp(21'($urandom_range('h110000, 'h1FFFFF)), 4);
      end else if (kind < 83) begin
         if ($urandom_range(0, 1)) append_byte(8'($urandom_range('h80, 'hBF)));
         else append_byte(8'($urandom_range('hF8, 'hFF)));
      end else if (kind < 95) begin
         // Truncated sequence, sometimes cut off by a lead byte.
         len = $urandom_range(2, 4);
         floor_cp = (len == 2) ? 'h80 : (len == 3) ? 'h800 : 'h10000;
         encode_cp(21'($urandom_range(floor_cp, (len == 4) ? 'h10FFFF : floor_cp * 2 - 1)), len);
         repeat ($urandom_range(1, len - 1)) void'(string_bytes.pop_back());
         if (kind >= 90) append_byte(8'($urandom_range('hC0, 'hFF)));
      end else begin
         append_byte(8'($urandom_range(0, 255)));
      end
   endfunction

   task automatic send_request(input logic cmd, input logic [7:0] value);
      int gap;
      gap = (burst_left > 0) ? 0 : pick_gap();
      if (burst_left > 0) burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_data_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      if (cmd == CMD_END) string_count++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Output side: open stretches of varying length broken by stalls.
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat (($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                              : $urandom_range(1, 20)) @(posedge clock);
         if (pick_gap() > 0) begin
            rsp_ready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("Timeout: no request or output byte moved for %0d cycles", IdleLimit);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int  n;
      int  random_target;
      bit  paused;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_cmd       = CMD_BYTE;
      req_data_byte = 8'h00;
      burst_left    = 0;
      sent_count    = 0;
      string_count  = 0;
      paused        = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part: plain text, every escape, the control range ends,
      // valid and rejected UTF-8, a broken sequence, a truncated end and an empty string.
      send_request(CMD_BYTE, 8'h41);
      send_request(CMD_BYTE, QUOTE);
      send_request(CMD_BYTE, BSLASH);
      send_request(CMD_BYTE, CODE_LF);
      send_request(CMD_BYTE, CODE_CR);
      send_request(CMD_BYTE, CODE_HT);
      send_request(CMD_BYTE, 8'h00);
      send_request(CMD_BYTE, 8'h1F);
      send_request(CMD_BYTE, 8'hFF);
      send_request(CMD_BYTE, 8'hE2);
      send_request(CMD_BYTE, 8'h82);
      send_request(CMD_BYTE, 8'hAC);
      send_request(CMD_BYTE, 8'hF4);
      send_request(CMD_BYTE, 8'h90);
      send_request(CMD_BYTE, 8'h80);
      send_request(CMD_BYTE, 8'h80);
      send_request(CMD_BYTE, 8'hC0);
      send_request(CMD_BYTE, 8'h80);
      send_request(CMD_BYTE, 8'hE2);
      send_request(CMD_BYTE, 8'h41);
      send_request(CMD_BYTE, 8'hF0);
      send_request(CMD_BYTE, 8'h9F);
      send_request(CMD_END, 8'h5A);
      send_request(CMD_END, 8'hA5);

      random_target = sent_count + RandomItems;
      while (sent_count < random_target) begin
         // Halfway through, hold off until the output has caught up completely.
         if (!paused && sent_count >= random_target - RandomItems / 2) begin
            drain_results();
            paused = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) begin
            send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end else begin
            string_bytes.delete();
            n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
            repeat (n) add_random_char();
            if ($urandom_range(0, 5) == 0) burst_left = $urandom_range(10, 40);
            foreach (string_bytes[i]) send_request(CMD_BYTE, string_bytes[i]);
            send_request(CMD_END, 8'($urandom_range(0, 255)));
         end
      end

      drain_results();
      repeat (24) @(posedge clock);

      $display("Sent %0d requests in %0d strings and checked %0d output bytes,",
               sent_count, string_count, checked_count);
      $display("covering escapes, UTF-8 of every length, malformed forms and stalls.");
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/jse_pkg.sv
rtl/jse_expand.sv
rtl/json_string_escaper_utf8_check_core.sv
test/json_escape_checker.sv
test/json_string_escaper_utf8_check_core_tb.sv
